// File: rtl/kms_pkg.sv
// shared types and constants of the k-mismatch substring search
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kms_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int MAX_TEXT    = 65536;

  localparam int SYM_W      = 8;
  localparam int OP_W       = 2;
  localparam int POS_W      = 16;
  localparam int CNT_W      = 6;
  localparam int ALLOW_W    = 6;
  localparam int CAP_W      = ALLOW_W + 1;
  localparam int CELL_CNT_W = CAP_W;
  localparam int PAT_LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int CELL_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int TEXT_CNT_W = $clog2(MAX_TEXT + 1);
  localparam int SPAN_W     = TEXT_CNT_W + PAT_LEN_W + POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2
  } kms_op_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [SYM_W-1:0] symbol;
    logic             text_last;
  } kms_cmd_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
    logic [CNT_W-1:0] mismatch_count;
  } kms_res_t;

  // one text byte or clear, handed from the cell row to the tracker
  typedef struct packed {
    logic                  valid;
    logic                  clear;
    logic                  last;
    logic                  tap;
    logic [CELL_CNT_W-1:0] cnt;
    logic [POS_W-1:0]      pos;
  } kms_event_t;

endpackage

// File: rtl/kms_cell.sv
// one cell of the mismatch chain: a pattern byte and one window's running count
// depends on kms_pkg
`timescale 1ns / 1ps

module kms_cell import kms_pkg::*; (
  input  logic                  clk,
  input  logic                  shift,
  input  logic                  load,
  input  logic [SYM_W-1:0]      sym,
  input  logic [CELL_CNT_W-1:0] cnt_in,
  input  logic [CAP_W-1:0]      cap,
  output logic [CELL_CNT_W-1:0] upd,
  output logic [CELL_CNT_W-1:0] cnt
);

  logic [SYM_W-1:0] pat;

  // count saturates at the cap
  assign upd = ((pat != sym) && (cnt_in < cap)) ? CELL_CNT_W'(cnt_in + 1'b1) : cnt_in;

  always_ff @(posedge clk) begin
    if (load) begin
      pat <= sym;
    end
    if (shift) begin
      cnt <= upd;
    end
  end

endmodule

// File: rtl/kms_tracker.sv
// best-window tracker and result register of the k-mismatch substring search
// depends on kms_pkg
`timescale 1ns / 1ps

module kms_tracker import kms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [ALLOW_W-1:0] allowance,
  input  kms_event_t         ev,
  output logic               ev_ready,
  output logic               res_valid,
  input  logic               res_stall,
  output kms_res_t           res
);

  logic             have;
  logic [POS_W-1:0] best_pos;
  logic [CNT_W-1:0] best_cnt;
  logic             have_next;
  logic [POS_W-1:0] best_pos_next;
  logic [CNT_W-1:0] best_cnt_next;
  logic             take;
  logic             hit;
  logic             res_valid_next;

  assign ev_ready = !(ev.last && res_valid && res_stall);
  assign take     = ev.valid && ev_ready;

  // strictly fewer mismatches replaces, so the earliest window wins a tie
  assign hit = ev.tap
            && (ev.cnt <= CELL_CNT_W'(allowance))
            && (!have || (ev.cnt < CELL_CNT_W'(best_cnt)));

  assign have_next     = have | hit;
  assign best_pos_next = hit ? ev.pos : best_pos;
  assign best_cnt_next = hit ? ev.cnt[CNT_W-1:0] : best_cnt;

  always_comb begin
    res_valid_next = res_valid && res_stall;
    if (take && ev.last) begin
      res_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      best_pos  <= '0;
      best_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
      if (take) begin
        if (ev.last || ev.clear) begin
          have     <= 1'b0;
          best_pos <= '0;
          best_cnt <= '0;
        end else begin
          have     <= have_next;
          best_pos <= best_pos_next;
          best_cnt <= best_cnt_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && ev.last) begin
      res.found          <= have_next;
      res.match_position <= best_pos_next;
      res.mismatch_count <= best_cnt_next;
    end
  end

endmodule

// File: rtl/k_mismatch_substring_search.sv
// top level of the k-mismatch (hamming distance) substring search
// depends on kms_pkg, kms_cell and kms_tracker
`timescale 1ns / 1ps

// Loads a pattern of up to MAX_PATTERN bytes and then streams text bytes, one
// per cycle while cmd_stall is low; a new cmd can be taken in the very next
// cycle. cmd_stall rises only while a finished result sits unread on res and
// another final text byte is waiting behind it. The pattern lives in a row of
// MAX_PATTERN cells; each text byte is compared in every cell at once and the
// running window counts move one cell down the row per byte, so the window that
// started pattern_length-1 bytes ago completes in the last used cell. A second
// stage keeps the earliest window with the fewest mismatches (counts saturate
// at the allowance plus one). The byte marked last passes the event register and
// the tracker's result register before its result leaves on res. Appends are
// ignored once text has started or the pattern is full, an empty pattern matches
// at position 0, and bytes beyond MAX_TEXT extend no window. The user must write
// mismatch_allowance via cfg_we/cfg_wdata only while idle; this is not enforced.

module k_mismatch_substring_search import kms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [ALLOW_W-1:0] cfg_wdata,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  kms_cmd_t           cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output kms_res_t           res
);

  // configuration
  logic [ALLOW_W-1:0] allowance;
  logic [CAP_W-1:0]   cap;

  // search state
  logic [PAT_LEN_W-1:0]  pat_len;
  logic [PAT_LEN_W-1:0]  pat_len_next;
  logic [TEXT_CNT_W-1:0] text_count;
  logic [TEXT_CNT_W-1:0] text_count_next;

  // handshake and decode
  logic accept;
  logic is_text;
  logic in_range;
  logic shift;
  logic append_ok;

  // cell row
  logic [CELL_CNT_W-1:0] chain_in [MAX_PATTERN];
  logic [CELL_CNT_W-1:0] cell_upd [MAX_PATTERN];
  logic [CELL_CNT_W-1:0] cell_cnt [MAX_PATTERN];
  logic [CELL_IDX_W-1:0] tap_idx;

  // window start arithmetic
  logic [SPAN_W-1:0] span_t;
  logic [SPAN_W-1:0] span_len;
  logic [SPAN_W-1:0] span_start;

  // event register between the cell row and the tracker
  kms_event_t ev;
  kms_event_t ev_next;
  logic       ev_ready;

  assign cmd_stall = ev.valid && !ev_ready;
  assign accept    = cmd_valid && !cmd_stall;

  assign cap = CAP_W'(allowance) + CAP_W'(1);

  always_comb begin
    is_text   = 1'b0;
    append_ok = 1'b0;
    case (cmd.opcode)
      OP_TEXT:   is_text = 1'b1;
      OP_APPEND: append_ok = (text_count == '0) && (pat_len < PAT_LEN_W'(MAX_PATTERN));
      default:   ;
    endcase
  end

  // text beyond the limit opens or extends no window
  assign in_range = text_count < TEXT_CNT_W'(MAX_TEXT);
  assign shift    = accept && is_text && in_range;

  // cells: each holds one pattern byte and the count of one open window
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign chain_in[k] = '0;
    end else begin : g_link
      assign chain_in[k] = cell_cnt[k-1];
    end

    kms_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .load   (accept && append_ok && (pat_len == PAT_LEN_W'(k))),
      .sym    (cmd.symbol),
      .cnt_in (chain_in[k]),
      .cap    (cap),
      .upd    (cell_upd[k]),
      .cnt    (cell_cnt[k])
    );
  end

  // the window that completes with this byte sits in cell pat_len-1
  assign tap_idx = CELL_IDX_W'(pat_len - PAT_LEN_W'(1));

  // window start = text index - (pattern length - 1)
  assign span_t     = SPAN_W'(text_count);
  assign span_len   = SPAN_W'(pat_len);
  assign span_start = span_t + SPAN_W'(1) - span_len;

  always_comb begin
    ev_next       = '0;
    ev_next.valid = accept && (is_text || (cmd.opcode == OP_CLEAR));
    ev_next.clear = cmd.opcode == OP_CLEAR;
    ev_next.last  = is_text && cmd.text_last;
    if (pat_len == '0) begin
      // empty pattern: the first text byte alone makes a match at zero
      ev_next.tap = is_text && (text_count == '0);
      ev_next.cnt = '0;
      ev_next.pos = '0;
    end else begin
      ev_next.tap = is_text && in_range && ((span_t + SPAN_W'(1)) >= span_len);
      ev_next.cnt = cell_upd[tap_idx];
      ev_next.pos = span_start[POS_W-1:0];
    end
  end

  always_comb begin
    pat_len_next    = pat_len;
    text_count_next = text_count;
    if (accept) begin
      case (cmd.opcode)
        OP_CLEAR: begin
          pat_len_next    = '0;
          text_count_next = '0;
        end
        OP_APPEND: begin
          if (append_ok) begin
            pat_len_next = pat_len + PAT_LEN_W'(1);
          end
        end
        OP_TEXT: begin
          if (cmd.text_last) begin
            text_count_next = '0;
          end else if (in_range) begin
            text_count_next = text_count + TEXT_CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allowance  <= '0;
      pat_len    <= '0;
      text_count <= '0;
      ev         <= '0;
    end else begin
      if (cfg_we) begin
        allowance <= cfg_wdata;
      end
      pat_len    <= pat_len_next;
      text_count <= text_count_next;
      // the event register moves whenever it is empty or the tracker takes it
      if (!ev.valid || ev_ready) begin
        ev <= ev_next;
      end
    end
  end

  kms_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .allowance (allowance),
    .ev        (ev),
    .ev_ready  (ev_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTHESIS
  // a found window never exceeds the allowance
  a_found_within: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.found |-> (res.mismatch_count <= allowance))
    else $error("reported window exceeds mismatch allowance");

  // input backs up only behind an unread result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (res_valid && res_stall))
    else $error("cmd stalled without a blocked result");

  // appends after text has started leave the pattern alone
  a_append_locked: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.opcode == OP_APPEND) && (text_count != '0) |=> pat_len == $past(pat_len))
    else $error("pattern changed during a search");

  // text counter stays within its limit
  a_text_bound: assert property (@(posedge clk) disable iff (rst)
    text_count <= TEXT_CNT_W'(MAX_TEXT))
    else $error("text counter past limit");
`endif

endmodule
